// ===== src/running_mean_variance_minmax_assert.svh =====
// Assertion macros shared by the checker of the running statistics block.
`ifndef RUNNING_MEAN_VARIANCE_MINMAX_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_MINMAX_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMV_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rmv_pkg.sv =====
// Shared constants, types and helpers of the running statistics block.
package rmv_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int ITER_BITS       = 7;

   localparam logic [1:0] UOP_DIV  = 2'd0;
   localparam logic [1:0] UOP_SQRT = 2'd1;
   localparam logic [1:0] UOP_MUL  = 2'd2;

   localparam logic ACT_ACCUMULATE = 1'b0;
   localparam logic ACT_CLEAR      = 1'b1;

   localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;
   localparam logic signed [31:0] Q_MAX32 = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q_MIN32 = 32'sh80000000;

   typedef struct packed {
      logic                 start;
      logic [1:0]           op;
      logic [ITER_BITS-1:0] iters;
   } iter_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > Q_MAX64) r = Q_MAX32;
      else if (v < Q_MIN64) r = Q_MIN32;
      else r = 32'(v);
      return r;
   endfunction

endpackage

// ===== src/rmv_iter_unit.sv =====
// Shared bit-serial unit: restoring divide, integer square root, shift-add multiply.
module rmv_iter_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  rmv_pkg::iter_req_type req,
   input  logic [63:0]          opa,
   input  logic [63:0]          opb,
   output logic                 done,
   output logic [63:0]          result
);
   import rmv_pkg::*;

   logic [63:0]          opa_ff, opa_in;
   logic [63:0]          opb_ff;
   logic [63:0]          res_ff, res_in;
   logic [65:0]          acc_ff, acc_in;
   logic [65:0]          lhs, rhs;
   logic [66:0]          sum;
   logic [1:0]           op_ff;
   logic [ITER_BITS-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic                 fits;

   // one result bit per cycle through a single add/subtract
   always_comb begin
      lhs    = '0;
      rhs    = '0;
      opa_in = opa_ff << 1;
      case (op_ff)
         UOP_DIV: begin
            lhs = {acc_ff[64:0], opa_ff[63]};
            rhs = {2'b00, opb_ff};
         end
         UOP_SQRT: begin
            lhs    = {acc_ff[63:0], opa_ff[63:62]};
            rhs    = {res_ff, 2'b01};
            opa_in = opa_ff << 2;
         end
         UOP_MUL: begin
            lhs = {acc_ff[64:0], 1'b0};
            rhs = opa_ff[63] ? {2'b00, opb_ff} : '0;
         end
         default: ;
      endcase
      sum    = (op_ff == UOP_MUL) ? ({1'b0, lhs} + {1'b0, rhs}) : ({1'b0, lhs} - {1'b0, rhs});
      fits   = ~sum[66];
      acc_in = (op_ff == UOP_MUL || fits) ? sum[65:0] : lhs;
      res_in = {res_ff[62:0], fits};
   end

   always_comb begin
      if (req.start) begin
         cnt_in  = req.iters;
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == ITER_BITS'(1));
      end else begin
         cnt_in  = cnt_ff;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         opa_ff <= opa;
         opb_ff <= opb;
         op_ff  <= req.op;
         acc_ff <= '0;
         res_ff <= '0;
      end else if (cnt_ff != '0) begin
         opa_ff <= opa_in;
         acc_ff <= acc_in;
         res_ff <= res_in;
      end
   end

   assign done   = done_ff;
   assign result = (op_ff == UOP_MUL) ? acc_ff[63:0] : res_ff;

endmodule

// ===== src/running_mean_variance_minmax.sv =====
// A clear, or an item without a valid sample, goes straight to the stddev step. A valid
// sample first passes the squarer, the extremes, the magnitude root (complex mode, small
// magnitudes only), three mean divides and the deviation product. The stddev step divides
// the variance and takes its root; it is skipped below two samples, and the root is skipped
// when the stddev saturates. Sync reset clears the state and statistics, not the result registers.
// One item at a time: ready returns the cycle after the result loads.
module running_mean_variance_minmax #(
   parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = rmv_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_re,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_im,
   input  logic                          req_sample_valid,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_valid_count,
   output logic signed [31:0]            rsp_mean_re,
   output logic signed [31:0]            rsp_mean_im,
   output logic signed [31:0]            rsp_ordering_mean,
   output logic [63:0]                   rsp_squared_deviation_sum,
   output logic signed [SAMPLE_BITS-1:0] rsp_max_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_max_im,
   output logic signed [SAMPLE_BITS-1:0] rsp_min_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_min_im,
   output logic                          rsp_extremes_defined,
   output logic [31:0]                   rsp_sample_stddev
);
   import rmv_pkg::*;

   localparam int SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int KEY_BITS = SQ_BITS + 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SQ     = 4'd1;
   localparam logic [3:0] S_EXT    = 4'd2;
   localparam logic [3:0] S_ORD    = 4'd3;
   localparam logic [3:0] S_ORD_W  = 4'd4;
   localparam logic [3:0] S_MEAN   = 4'd5;
   localparam logic [3:0] S_MEAN_W = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_MUL_W  = 4'd8;
   localparam logic [3:0] S_STD    = 4'd9;
   localparam logic [3:0] S_STD_W  = 4'd10;
   localparam logic [3:0] S_ROOT_W = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0]                   state_ff;
   logic                         mode_ff;
   logic                         rsp_valid_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   logic signed [31:0]           mean_re_ff, mean_im_ff, ord_mean_ff;
   logic [63:0]                  dev_ff;
   logic signed [SAMPLE_BITS-1:0] max_re_ff, max_im_ff, min_re_ff, min_im_ff;
   logic                         seen_ff;

   logic signed [SAMPLE_BITS-1:0] sre_ff, sim_ff;
   logic signed [31:0]           x_re_ff, x_im_ff, x_ord_ff;
   logic [SQ_BITS-1:0]           sq_ff [6];
   logic [2:0]                   sq_idx_ff;
   logic [1:0]                   m_idx_ff;
   logic                         neg_ff;
   logic [31:0]                  mag_ff, after_ff, std_ff;

   logic [31:0]                  rsp_count_ff, rsp_std_ff;
   logic signed [31:0]           rsp_mean_re_ff, rsp_mean_im_ff, rsp_ord_ff;
   logic [63:0]                  rsp_dev_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_max_re_ff, rsp_max_im_ff, rsp_min_re_ff, rsp_min_im_ff;
   logic                         rsp_seen_ff;

   iter_req_type                 ureq;
   logic [63:0]                  uopa, uopb, ures;
   logic                         udone;

   logic [63:0]                  cnt64;
   logic signed [SAMPLE_BITS-1:0] sim_in;
   logic signed [31:0]           x_re_in, x_im_in;
   logic signed [SAMPLE_BITS-1:0] sq_op;
   logic signed [SQ_BITS-1:0]    sq_prod;
   logic [KEY_BITS-1:0]          key_s, key_max, key_min;
   logic [63:0]                  s64;
   logic                         s_small;
   logic                         gt_max, lt_min;
   logic signed [31:0]           x_sel, mean_sel, mean_new;
   logic signed [32:0]           delta, after;
   logic [31:0]                  delta_mag, after_mag;
   logic signed [33:0]           qs, msum;
   logic [64:0]                  dev_sum;
   logic                         var_big;
   logic                         out_load;

   rmv_iter_unit u_iter (
      .clock  (clock),
      .reset  (reset),
      .req    (ureq),
      .opa    (uopa),
      .opb    (uopb),
      .done   (udone),
      .result (ures)
   );

   assign cnt64    = 64'(count_ff);
   assign sim_in   = mode_ff ? req_sample_im : '0;
   assign x_re_in  = sat32(64'(req_sample_re) <<< 16);
   assign x_im_in  = sat32(64'(sim_in) <<< 16);
   assign out_load = !rsp_valid_ff || rsp_ready;

   // one squarer, stepped over sample, max and min parts
   always_comb begin
      case (sq_idx_ff)
         3'd0:    sq_op = sre_ff;
         3'd1:    sq_op = sim_ff;
         3'd2:    sq_op = max_re_ff;
         3'd3:    sq_op = max_im_ff;
         3'd4:    sq_op = min_re_ff;
         3'd5:    sq_op = min_im_ff;
         default: sq_op = '0;
      endcase
      sq_prod = sq_op * sq_op;
   end

   assign key_s   = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
   assign key_max = {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};
   assign key_min = {1'b0, sq_ff[4]} + {1'b0, sq_ff[5]};
   assign s64     = 64'(key_s);
   assign s_small = (s64[63:30] == '0);
   assign gt_max  = !seen_ff || (mode_ff ? (key_s > key_max) : (sre_ff > max_re_ff));
   assign lt_min  = !seen_ff || (mode_ff ? (key_s < key_min) : (sre_ff < min_re_ff));

   always_comb begin
      case (m_idx_ff)
         2'd0: begin
            x_sel    = x_re_ff;
            mean_sel = mean_re_ff;
         end
         2'd1: begin
            x_sel    = x_im_ff;
            mean_sel = mean_im_ff;
         end
         default: begin
            x_sel    = x_ord_ff;
            mean_sel = ord_mean_ff;
         end
      endcase
      delta     = {x_sel[31], x_sel} - {mean_sel[31], mean_sel};
      delta_mag = delta[32] ? 32'(-delta) : delta[31:0];
      qs        = neg_ff ? -$signed({2'b00, ures[31:0]}) : $signed({2'b00, ures[31:0]});
      msum      = {{2{mean_sel[31]}}, mean_sel} + qs;
      mean_new  = sat32(64'(msum));
      after     = {x_ord_ff[31], x_ord_ff} - {mean_new[31], mean_new};
      after_mag = after[32] ? 32'(-after) : after[31:0];
   end

   assign dev_sum = {1'b0, dev_ff} + {17'b0, ures[63:16]};
   assign var_big = (ures[63:48] != '0);

   // requests to the shared unit
   always_comb begin
      ureq = '0;
      uopa = '0;
      uopb = '0;
      case (state_ff)
         S_ORD: begin
            ureq.start = mode_ff && s_small;
            ureq.op    = UOP_SQRT;
            ureq.iters = ITER_BITS'(31);
            uopa       = s64 << 34;
         end
         S_MEAN: begin
            ureq.start = 1'b1;
            ureq.op    = UOP_DIV;
            ureq.iters = ITER_BITS'(32);
            uopa       = {delta_mag, 32'b0};
            uopb       = cnt64;
         end
         S_MUL: begin
            ureq.start = 1'b1;
            ureq.op    = UOP_MUL;
            ureq.iters = ITER_BITS'(32);
            uopa       = {mag_ff, 32'b0};
            uopb       = {32'b0, after_ff};
         end
         S_STD: begin
            ureq.start = (cnt64 >= 64'd2);
            ureq.op    = UOP_DIV;
            ureq.iters = ITER_BITS'(64);
            uopa       = dev_ff;
            uopb       = cnt64 - 64'd1;
         end
         S_STD_W: begin
            ureq.start = udone && !var_big;
            ureq.op    = UOP_SQRT;
            ureq.iters = ITER_BITS'(32);
            uopa       = ures << 16;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         mean_re_ff   <= '0;
         mean_im_ff   <= '0;
         ord_mean_ff  <= '0;
         dev_ff       <= '0;
         max_re_ff    <= '0;
         max_im_ff    <= '0;
         min_re_ff    <= '0;
         min_im_ff    <= '0;
         seen_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (state_ff == S_OUT && out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_valid) begin
               if (req_action == ACT_CLEAR) begin
                  count_ff    <= '0;
                  mean_re_ff  <= '0;
                  mean_im_ff  <= '0;
                  ord_mean_ff <= '0;
                  dev_ff      <= '0;
                  max_re_ff   <= '0;
                  max_im_ff   <= '0;
                  min_re_ff   <= '0;
                  min_im_ff   <= '0;
                  seen_ff     <= 1'b0;
                  state_ff    <= S_STD;
               end else if (req_sample_valid) begin
                  if (count_ff != '1) count_ff <= count_ff + 1'b1;
                  state_ff <= S_SQ;
               end else begin
                  state_ff <= S_STD;
               end
            end
            S_SQ: if (sq_idx_ff == 3'd5) state_ff <= S_EXT;
            S_EXT: begin
               if (gt_max) begin
                  max_re_ff <= sre_ff;
                  max_im_ff <= sim_ff;
               end
               if (lt_min) begin
                  min_re_ff <= sre_ff;
                  min_im_ff <= sim_ff;
               end
               seen_ff  <= 1'b1;
               state_ff <= S_ORD;
            end
            S_ORD: state_ff <= (mode_ff && s_small) ? S_ORD_W : S_MEAN;
            S_ORD_W: if (udone) state_ff <= S_MEAN;
            S_MEAN: state_ff <= S_MEAN_W;
            S_MEAN_W: if (udone) begin
               case (m_idx_ff)
                  2'd0:    mean_re_ff  <= mean_new;
                  2'd1:    mean_im_ff  <= mean_new;
                  default: ord_mean_ff <= mean_new;
               endcase
               state_ff <= (m_idx_ff == 2'd2) ? S_MUL : S_MEAN;
            end
            S_MUL: state_ff <= S_MUL_W;
            S_MUL_W: if (udone) begin
               dev_ff   <= dev_sum[64] ? '1 : dev_sum[63:0];
               state_ff <= S_STD;
            end
            S_STD: state_ff <= (cnt64 < 64'd2) ? S_OUT : S_STD_W;
            S_STD_W: if (udone) state_ff <= var_big ? S_OUT : S_ROOT_W;
            S_ROOT_W: if (udone) state_ff <= S_OUT;
            S_OUT: if (out_load) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            sre_ff    <= req_sample_re;
            sim_ff    <= sim_in;
            x_re_ff   <= x_re_in;
            x_im_ff   <= x_im_in;
            sq_idx_ff <= '0;
            m_idx_ff  <= '0;
         end
         S_SQ: begin
            sq_ff[sq_idx_ff] <= sq_prod;
            sq_idx_ff        <= sq_idx_ff + 1'b1;
         end
         S_ORD: if (!(mode_ff && s_small)) x_ord_ff <= mode_ff ? Q_MAX32 : x_re_ff;
         S_ORD_W: if (udone) x_ord_ff <= ures[31:0];
         S_MEAN: begin
            neg_ff <= delta[32];
            mag_ff <= delta_mag;
         end
         S_MEAN_W: if (udone) begin
            after_ff <= after_mag;
            m_idx_ff <= m_idx_ff + 1'b1;
         end
         S_STD: if (cnt64 < 64'd2) std_ff <= '0;
         S_STD_W: if (udone && var_big) std_ff <= '1;
         S_ROOT_W: if (udone) std_ff <= ures[31:0];
         S_OUT: if (out_load) begin
            rsp_count_ff   <= (cnt64 > 64'hFFFF_FFFF) ? '1 : cnt64[31:0];
            rsp_mean_re_ff <= mean_re_ff;
            rsp_mean_im_ff <= mean_im_ff;
            rsp_ord_ff     <= ord_mean_ff;
            rsp_dev_ff     <= dev_ff;
            rsp_max_re_ff  <= max_re_ff;
            rsp_max_im_ff  <= max_im_ff;
            rsp_min_re_ff  <= min_re_ff;
            rsp_min_im_ff  <= min_im_ff;
            rsp_seen_ff    <= seen_ff;
            rsp_std_ff     <= std_ff;
         end
         default: ;
      endcase
   end

   assign req_ready                 = (state_ff == S_IDLE);
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_valid_count           = rsp_count_ff;
   assign rsp_mean_re               = rsp_mean_re_ff;
   assign rsp_mean_im               = rsp_mean_im_ff;
   assign rsp_ordering_mean         = rsp_ord_ff;
   assign rsp_squared_deviation_sum = rsp_dev_ff;
   assign rsp_max_re                = rsp_max_re_ff;
   assign rsp_max_im                = rsp_max_im_ff;
   assign rsp_min_re                = rsp_min_re_ff;
   assign rsp_min_im                = rsp_min_im_ff;
   assign rsp_extremes_defined      = rsp_seen_ff;
   assign rsp_sample_stddev         = rsp_std_ff;

endmodule

// ===== src/rmv_checker.sv =====
// Port-level checker for the running statistics block, bound to the top level.
`include "running_mean_variance_minmax_assert.svh"

module rmv_checker #(
   parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [31:0]                   rsp_valid_count,
   input logic signed [SAMPLE_BITS-1:0] rsp_max_re,
   input logic signed [SAMPLE_BITS-1:0] rsp_max_im,
   input logic signed [SAMPLE_BITS-1:0] rsp_min_re,
   input logic signed [SAMPLE_BITS-1:0] rsp_min_im,
   input logic                          rsp_extremes_defined,
   input logic [31:0]                   rsp_sample_stddev
);

   `RMV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped before transfer")

   `RMV_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready, "ready right after a transfer")

   `RMV_ASSERT_SAME(a_no_extremes_zero, rsp_valid && !rsp_extremes_defined, rsp_max_re == '0 && rsp_max_im == '0 && rsp_min_re == '0 && rsp_min_im == '0, "extremes not zero while undefined")

   `RMV_ASSERT_SAME(a_stddev_low_count, rsp_valid && rsp_valid_count < 32'd2, rsp_sample_stddev == '0, "stddev nonzero below two samples")

   `RMV_ASSERT_SAME(a_empty_no_extremes, rsp_valid && rsp_valid_count == '0, !rsp_extremes_defined, "extremes defined with zero count")

endmodule

bind running_mean_variance_minmax rmv_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rmv_checker (.*);
